// ===== design/tkns_pkg.sv =====
// ----------------------------------------------------------------------------
// tkns_pkg - top-K nearest select shared definitions
// Widths, list depth, payload structs and the candidate ordering function.
// ----------------------------------------------------------------------------
package tkns_pkg;

    localparam int K_BEST   = 10;
    localparam int KEY_BITS = 32;
    localparam int ID_BITS  = 14;
    localparam int RANK_BITS = 4;
    localparam int CNT_W    = $clog2(K_BEST + 1);
    localparam int IDX_W    = (K_BEST > 1) ? $clog2(K_BEST) : 1;

    typedef struct packed {
        logic [KEY_BITS-1:0] cand_key;
        logic [ID_BITS-1:0]  cand_id;
        logic                first;
        logic                last;
    } cand_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  out_key;
        logic [ID_BITS-1:0]   out_id;
        logic                 is_entry;
        logic [RANK_BITS-1:0] rank;
        logic                 full_res;
        logic                 last_result;
    } res_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_BITS-1:0]  id;
    } entry_t;

    // a is better than b: smaller key, or equal key and smaller id
    function automatic logic beats(entry_t a, entry_t b);
        beats = (a.key < b.key) || ((a.key == b.key) && (a.id < b.id));
    endfunction

endpackage

// ===== design/top_k_nearest_select_core.sv =====
// ----------------------------------------------------------------------------
// top_k_nearest_select_core - keeps the K best nearest-neighbour candidates
// Sorted insertion list with one status result per candidate and a sorted
// readout of the held entries after a candidate flagged last.
// ----------------------------------------------------------------------------
// A candidate's status result is presented in the cycle after its transfer.
// Throughput: one candidate per cycle unless res_ready stalls; a last-flagged
// candidate then drains up to K_BEST held entries through the single output
// register, blocking candidates. Reset (rst_n low, asynchronous) empties the
// list and drops any pending result; list contents stay, only the count clears.
// ----------------------------------------------------------------------------
module top_k_nearest_select_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cand_valid,
    output logic             cand_ready,
    input  tkns_pkg::cand_t  cand,
    output logic             res_valid,
    input  logic             res_ready,
    output tkns_pkg::res_t   res
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    // Sorted list, slot 0 is the best entry. Only slots below the count are
    // meaningful; the rest hold stale data and are never presented.
    tkns_pkg::entry_t                   list_reg [tkns_pkg::K_BEST];
    tkns_pkg::entry_t                   list_next [tkns_pkg::K_BEST];
    logic [tkns_pkg::CNT_W-1:0]         held_count_reg;
    logic [tkns_pkg::CNT_W-1:0]         held_count_next;

    // Output register and readout sequencer
    logic                               out_valid_reg;
    tkns_pkg::res_t                     out_reg;
    logic                               ro_active_reg;
    logic [tkns_pkg::CNT_W-1:0]         ro_idx_reg;

    // ------------------------------------------------------------------
    // Insertion datapath: K parallel compares, then a per-slot
    // keep / insert / shift-down select.
    // ------------------------------------------------------------------
    tkns_pkg::entry_t                   cand_entry;
    logic [tkns_pkg::CNT_W-1:0]         eff_count;
    logic [tkns_pkg::K_BEST-1:0]        better;
    logic [tkns_pkg::K_BEST-1:0]        keep;
    logic                               do_insert;
    logic                               cand_xfer;
    logic                               out_free;
    logic                               full_new;
    logic [tkns_pkg::KEY_BITS-1:0]      thresh;

    assign cand_entry.key = cand.cand_key;
    assign cand_entry.id  = cand.cand_id;

    // A first-flagged candidate sees an empty list
    assign eff_count = cand.first ? '0 : held_count_reg;

    always_comb
    begin
        for (int i = 0; i < tkns_pkg::K_BEST; i++)
        begin
            better[i] = tkns_pkg::beats(cand_entry, list_reg[i]);
            keep[i]   = (tkns_pkg::CNT_W'(i) < eff_count) && !better[i];
        end
    end

    // Not full: always insert. Full: only if strictly better than the worst.
    assign do_insert = (eff_count < tkns_pkg::CNT_W'(tkns_pkg::K_BEST))
                       || better[tkns_pkg::K_BEST-1];

    always_comb
    begin
        list_next[0] = keep[0] ? list_reg[0] : cand_entry;
        for (int i = 1; i < tkns_pkg::K_BEST; i++)
        begin
            if (keep[i])
            begin
                list_next[i] = list_reg[i];
            end
            else if (keep[i-1])
            begin
                list_next[i] = cand_entry;
            end
            else
            begin
                list_next[i] = list_reg[i-1];
            end
        end
    end

    assign held_count_next = (eff_count < tkns_pkg::CNT_W'(tkns_pkg::K_BEST))
                             ? eff_count + 1'b1
                             : tkns_pkg::CNT_W'(tkns_pkg::K_BEST);

    assign full_new = (held_count_next == tkns_pkg::CNT_W'(tkns_pkg::K_BEST));

    // Pruning threshold: worst held key once full, all ones before that
    always_comb
    begin
        if (!full_new)
        begin
            thresh = '1;
        end
        else if (do_insert)
        begin
            thresh = list_next[tkns_pkg::K_BEST-1].key;
        end
        else
        begin
            thresh = list_reg[tkns_pkg::K_BEST-1].key;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The list is frozen during a readout, so new candidates
    // wait until the last entry has been loaded into the output register.
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || res_ready;
    assign cand_ready = !ro_active_reg && out_free;
    assign cand_xfer  = cand_valid && cand_ready;

    // Readout entry at the current index
    tkns_pkg::entry_t                   ro_entry;
    logic                               ro_final;

    assign ro_entry = list_reg[ro_idx_reg[tkns_pkg::IDX_W-1:0]];
    assign ro_final = ((ro_idx_reg + 1'b1) == held_count_reg);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (cand_xfer && do_insert)
        begin
            for (int i = 0; i < tkns_pkg::K_BEST; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            ro_active_reg  <= 1'b0;
            ro_idx_reg     <= '0;
        end
        else
        begin
            if (cand_xfer)
            begin
                held_count_reg <= held_count_next;
                out_valid_reg  <= 1'b1;
                ro_active_reg  <= cand.last;
                ro_idx_reg     <= '0;
            end
            else if (ro_active_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (ro_final)
                begin
                    ro_active_reg <= 1'b0;
                end
                ro_idx_reg <= ro_idx_reg + 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cand_xfer)
        begin
            out_reg.out_key     <= thresh;
            out_reg.out_id      <= '0;
            out_reg.is_entry    <= 1'b0;
            out_reg.rank        <= '0;
            out_reg.full_res    <= full_new;
            out_reg.last_result <= !cand.last;
        end
        else if (ro_active_reg && out_free)
        begin
            out_reg.out_key     <= ro_entry.key;
            out_reg.out_id      <= ro_entry.id;
            out_reg.is_entry    <= 1'b1;
            out_reg.rank        <= tkns_pkg::RANK_BITS'(ro_idx_reg);
            out_reg.full_res    <= (held_count_reg == tkns_pkg::CNT_W'(tkns_pkg::K_BEST));
            out_reg.last_result <= ro_final;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
